>>> rtl/a6ff_pkg.sv
package a6ff_pkg;

  localparam logic [7:0] HEAD_MARK = 8'hA6;
  localparam logic [7:0] END_MARK = 8'h6A;
  localparam int unsigned MIN_BUFFER = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_item_t;

  typedef struct packed {
    logic       frame_found;
    logic [7:0] frame_start;
    logic [7:0] payload_length;
    logic       overflowed;
  } result_t;

  // which address the store is read at
  typedef enum logic [2:0] {
    RD_START,
    RD_LEN,
    RD_END,
    RD_PAYLOAD0,
    RD_PTR
  } addr_sel_t;

  typedef struct packed {
    logic      load;       // append the incoming byte
    addr_sel_t addr_sel;
    logic      scan_init;  // candidate index back to zero
    logic      next_cand;  // move on to the next candidate index
    logic      latch_len;  // take length byte, seed the sum
    logic      sum_init;   // set up the payload walk
    logic      sum_step;   // add one payload byte
    logic      finish;     // emit the result, empty the buffer
    logic      found;
  } cmd_t;

  typedef struct packed {
    logic count_short;   // fewer than the minimum bytes stored
    logic cand_done;     // candidate index reached the byte count
    logic head_ok;
    logic len_ok;        // nonzero length and end byte inside the buffer
    logic end_ok;
    logic sum_ok;
    logic last_payload;
  } status_t;

endpackage

>>> rtl/a6ff_ctrl.sv
module a6ff_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             last_byte,
  input  a6ff_pkg::status_t stat,
  output logic             busy,
  output a6ff_pkg::cmd_t   cmd
);

  typedef enum logic [2:0] {
    IDLE,
    INIT,
    HEAD,
    LEN,
    CHK_LEN,
    CHK_END,
    SUM,
    CHK_SUM
  } state_t;

  state_t state, state_next;

  assign busy = (state != IDLE);

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.addr_sel  = a6ff_pkg::RD_START;
    case (state)
      IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (last_byte) begin
            state_next = INIT;
          end
        end
      end
      INIT: begin
        cmd.scan_init = 1'b1;
        if (stat.count_short) begin
          cmd.finish = 1'b1;
          state_next = IDLE;
        end else begin
          state_next = HEAD;
        end
      end
      HEAD: begin
        // read the candidate head byte
        cmd.addr_sel = a6ff_pkg::RD_START;
        if (stat.cand_done) begin
          cmd.finish = 1'b1;
          state_next = IDLE;
        end else begin
          state_next = LEN;
        end
      end
      LEN: begin
        cmd.addr_sel = a6ff_pkg::RD_LEN;
        if (stat.head_ok) begin
          state_next = CHK_LEN;
        end else begin
          cmd.next_cand = 1'b1;
          state_next    = HEAD;
        end
      end
      CHK_LEN: begin
        cmd.addr_sel = a6ff_pkg::RD_END;
        if (stat.len_ok) begin
          cmd.latch_len = 1'b1;
          state_next    = CHK_END;
        end else begin
          cmd.next_cand = 1'b1;
          state_next    = HEAD;
        end
      end
      CHK_END: begin
        cmd.addr_sel = a6ff_pkg::RD_PAYLOAD0;
        if (stat.end_ok) begin
          cmd.sum_init = 1'b1;
          state_next   = SUM;
        end else begin
          cmd.next_cand = 1'b1;
          state_next    = HEAD;
        end
      end
      SUM: begin
        cmd.addr_sel = a6ff_pkg::RD_PTR;
        cmd.sum_step = 1'b1;
        if (stat.last_payload) begin
          state_next = CHK_SUM;
        end
      end
      CHK_SUM: begin
        if (stat.sum_ok) begin
          cmd.finish = 1'b1;
          cmd.found  = 1'b1;
          state_next = IDLE;
        end else begin
          cmd.next_cand = 1'b1;
          state_next    = HEAD;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/a6ff_datapath.sv
module a6ff_datapath #(
  parameter int unsigned BUFFER_DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  a6ff_pkg::byte_item_t byte_item,
  input  a6ff_pkg::cmd_t       cmd,
  output a6ff_pkg::status_t    stat,
  output a6ff_pkg::result_t    result,
  output logic                 result_valid
);

  localparam int unsigned IW = $clog2(BUFFER_DEPTH);
  localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned EW = ((CW > 8) ? CW : 8) + 2;

  logic [7:0]    mem [BUFFER_DEPTH];
  logic [7:0]    rd_data;
  logic [EW-1:0] rd_addr;

  logic [CW-1:0] count;
  logic          overflow;
  logic [CW-1:0] cand;
  logic [7:0]    len;
  logic [7:0]    sum;
  logic [7:0]    remain;
  logic [EW-1:0] ptr;

  logic [EW-1:0] cand_ext;
  logic [EW-1:0] count_ext;
  logic [EW-1:0] end_idx;
  logic          has_room;

  assign cand_ext  = EW'(cand);
  assign count_ext = EW'(count);
  assign end_idx   = cand_ext + EW'(rd_data) + EW'(3);
  assign has_room  = (count < CW'(BUFFER_DEPTH));

  always_comb begin
    case (cmd.addr_sel)
      a6ff_pkg::RD_START:    rd_addr = cand_ext;
      a6ff_pkg::RD_LEN:      rd_addr = cand_ext + EW'(1);
      a6ff_pkg::RD_END:      rd_addr = end_idx;
      a6ff_pkg::RD_PAYLOAD0: rd_addr = cand_ext + EW'(2);
      a6ff_pkg::RD_PTR:      rd_addr = ptr;
      default:               rd_addr = cand_ext;
    endcase
  end

  always_comb begin
    stat.count_short  = (count < CW'(a6ff_pkg::MIN_BUFFER));
    stat.cand_done    = (cand >= count);
    stat.head_ok      = (rd_data == a6ff_pkg::HEAD_MARK);
    stat.len_ok       = (rd_data != 8'd0) && (end_idx < count_ext);
    stat.end_ok       = (rd_data == a6ff_pkg::END_MARK);
    stat.sum_ok       = (rd_data == sum);
    stat.last_payload = (remain == 8'd1);
  end

  // byte store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.load && has_room) begin
      mem[count[IW-1:0]] <= byte_item.data_byte;
    end
    rd_data <= mem[rd_addr[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      overflow     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.finish;
      if (cmd.load) begin
        if (has_room) begin
          count <= count + CW'(1);
        end else begin
          overflow <= 1'b1;
        end
      end
      if (cmd.finish) begin
        count    <= '0;
        overflow <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      cand <= '0;
    end else if (cmd.next_cand) begin
      cand <= cand + CW'(1);
    end
    if (cmd.latch_len) begin
      len <= rd_data;
      sum <= rd_data;
    end else if (cmd.sum_step) begin
      sum <= sum + rd_data;
    end
    if (cmd.sum_init) begin
      ptr    <= cand_ext + EW'(3);
      remain <= len;
    end else if (cmd.sum_step) begin
      ptr    <= ptr + EW'(1);
      remain <= remain - 8'd1;
    end
    if (cmd.finish) begin
      result.frame_found    <= cmd.found;
      result.frame_start    <= cmd.found ? cand_ext[7:0] : 8'd0;
      result.payload_length <= cmd.found ? len : 8'd0;
      result.overflowed     <= overflow;
    end
  end

endmodule

>>> rtl/a6_frame_finder_core.sv
// channel   | ports                          | handshake
// ----------+--------------------------------+----------------------------------
// byte in   | start, busy, byte_item         | item taken when start && !busy
// result    | result_valid, result           | one-cycle strobe, always taken
//
// a byte that is not the last is taken and busy stays low
// the last byte starts a scan, busy high until the result strobe: a set-up
// step, a head check per start index, length and end checks where the head
// matches, a checksum walk over the payload, a closing step if no frame
// synchronous reset clears byte count, overflow flag and controller state; the
// byte store is not cleared, only written entries decide the result
// the result cannot be stalled; it is shown for exactly one cycle
module a6_frame_finder_core #(
  parameter int unsigned BUFFER_DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  a6ff_pkg::byte_item_t byte_item,
  output logic                 result_valid,
  output a6ff_pkg::result_t    result
);

  // command and status between sequencer and datapath
  a6ff_pkg::cmd_t    cmd;
  a6ff_pkg::status_t stat;

  // sequencer: byte loading in idle, then the frame scan
  a6ff_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .last_byte (byte_item.last_byte),
    .stat      (stat),
    .busy      (busy),
    .cmd       (cmd)
  );

  // byte store, scan index, running checksum and result register
  a6ff_datapath #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .byte_item    (byte_item),
    .cmd          (cmd),
    .stat         (stat),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule

>>> tb/sv/a6ff_frame_checker.sv
module a6ff_frame_checker #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  a6ff_pkg::byte_item_t byte_item,
  input  logic                 result_valid,
  input  a6ff_pkg::result_t    result,
  output int unsigned          fail_count,
  output int unsigned          outstanding,
  output int unsigned          results_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import a6ff_pkg::*;

  // shadow of the received buffer
  logic [7:0]  byte_mem [0:DEPTH-1];
  int unsigned fill;
  bit          dropped;

  result_t     results_due [$];
  int unsigned errors;
  int unsigned checked;

  initial begin
    errors = 0;
    checked = 0;
    fill = 0;
    dropped = 1'b0;
    fail_count = 0;
    outstanding = 0;
    results_seen = 0;
  end

  // is there a well-formed frame with its head at index s
  function automatic bit frame_at(input int unsigned s, output logic [7:0] len);
    logic [7:0]  sum;
    int unsigned tail;
    len = '0;
    if (byte_mem[s] != HEAD_MARK || s + 1 >= fill) return 1'b0;
    len = byte_mem[s + 1];
    if (len == 8'd0) return 1'b0;
    tail = s + len + 3;
    if (tail >= fill) return 1'b0;
    if (byte_mem[tail] != END_MARK) return 1'b0;
    sum = len;
    for (int unsigned k = 0; k < len; k++) sum = sum + byte_mem[s + 2 + k];
    return sum == byte_mem[s + len + 2];
  endfunction

  // first valid frame from the lowest index
  function automatic result_t scan_buffer();
    result_t    r;
    logic [7:0] len;
    r = '0;
    r.overflowed = dropped;
    if (fill >= MIN_BUFFER) begin
      for (int unsigned s = 0; s < fill && !r.frame_found; s++) begin
        if (frame_at(s, len)) begin
          r.frame_found = 1'b1;
          r.frame_start = 8'(s);
          r.payload_length = len;
        end
      end
    end
    return r;
  endfunction

  function automatic void compare_field(input string field, input logic [7:0] want,
                                        input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      fill = 0;
      dropped = 1'b0;
      results_due.delete();
    end else begin
      if (result_valid) begin
        checked++;
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual found %0d start %0d len %0d ovf %0d",
                   $time, result.frame_found, result.frame_start, result.payload_length,
                   result.overflowed);
          errors++;
        end else begin
          want = results_due.pop_front();
          compare_field("frame_found", 8'(want.frame_found), 8'(result.frame_found));
          compare_field("frame_start", want.frame_start, result.frame_start);
          compare_field("payload_length", want.payload_length, result.payload_length);
          compare_field("overflowed", 8'(want.overflowed), 8'(result.overflowed));
        end
      end
      if (start && !busy) begin
        if (fill < DEPTH) begin
          byte_mem[fill] = byte_item.data_byte;
          fill++;
        end else begin
          dropped = 1'b1;
        end
        if (byte_item.last_byte) begin
          results_due.push_back(scan_buffer());
          fill = 0;
          dropped = 1'b0;
        end
      end
    end
    fail_count <= errors;
    outstanding <= results_due.size();
    results_seen <= checked;
  end

endmodule

>>> tb/sv/a6_frame_finder_core_test.sv
module a6_frame_finder_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import a6ff_pkg::*;

  localparam int unsigned DEPTH = 256;
  localparam int unsigned PERIOD = 20;
  localparam int unsigned ITEM_TARGET = 650;
  // limit on the whole run, with a wide margin over the worst scan of a full
  // buffer and the scans of the small buffers
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned TAIL_CYCLES = 64;

  // ways a generated frame can be spoilt
  typedef enum int {
    INTACT,
    BAD_SUM,
    BAD_END,
    ZERO_LEN,
    CUT_SHORT
  } flaw_t;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  byte_item_t byte_item;
  logic       result_valid;
  result_t    result;

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned results_seen;

  logic [7:0]  bytes_q [$];
  int unsigned bytes_sent;
  int unsigned buffers_sent;
  int unsigned overflow_buffers;
  int unsigned cycles;

  a6_frame_finder_core #(
    .BUFFER_DEPTH(DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .byte_item(byte_item),
    .result_valid(result_valid),
    .result(result)
  );

  a6ff_frame_checker #(
    .DEPTH(DEPTH)
  ) checker_i (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .byte_item(byte_item),
    .result_valid(result_valid),
    .result(result),
    .fail_count(fail_count),
    .outstanding(outstanding),
    .results_seen(results_seen)
  );

  initial clk = 1'b0;
  always #(PERIOD / 2) clk = ~clk;

  // watchdog: a hung scan or a lost result ends the run here
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timed out after %0d cycles with %0d results outstanding", cycles, outstanding);
    $display("a6_frame_finder_core regression: fail");
    $finish;
  end

  // one item onto the byte channel; called at a falling edge, returns at one
  task automatic send_byte(input logic [7:0] value, input logic is_last);
    bit quiet;
    // a stretch of the run with the sender never pausing
    quiet = bytes_sent >= 120 && bytes_sent < 280;
    // idle cycles drawn one at a time, about 31 in a hundred
    while (!quiet && $urandom_range(99) < 31) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    byte_item <= '{data_byte: value, last_byte: is_last};
    // taken at the first rising edge with busy low
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  // whole buffer out, last item flagged to start the scan
  task automatic send_buffer();
    int unsigned n;
    n = bytes_q.size();
    for (int unsigned i = 0; i < n; i++) send_byte(bytes_q[i], i == n - 1);
    bytes_q.delete();
    buffers_sent++;
  endtask

  // filler, optionally leaning towards the marker values so that false
  // heads and stray end bytes turn up often
  task automatic add_noise(input int unsigned n, input bit biased);
    int unsigned pick;
    for (int unsigned i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (biased && pick < 20) bytes_q.push_back(HEAD_MARK);
      else if (biased && pick < 32) bytes_q.push_back(END_MARK);
      else bytes_q.push_back(8'($urandom));
    end
  endtask

  task automatic add_frame(input int unsigned len, input flaw_t flaw);
    logic [7:0] sum;
    logic [7:0] len_byte;
    logic [7:0] payload;
    len_byte = (flaw == ZERO_LEN) ? 8'h00 : 8'(len);
    bytes_q.push_back(HEAD_MARK);
    bytes_q.push_back(len_byte);
    sum = len_byte;
    for (int unsigned k = 0; k < len; k++) begin
      payload = 8'($urandom);
      sum = sum + payload;
      bytes_q.push_back(payload);
    end
    // a checksum off by some nonzero amount
    if (flaw == BAD_SUM) sum = sum + 8'($urandom_range(1, 255));
    bytes_q.push_back(sum);
    if (flaw == BAD_END) bytes_q.push_back(END_MARK ^ 8'($urandom_range(1, 255)));
    else if (flaw != CUT_SHORT) bytes_q.push_back(END_MARK);
  endtask

  initial begin
    int unsigned len;
    rst = 1'b1;
    start = 1'b0;
    byte_item = '0;
    bytes_sent = 0;
    buffers_sent = 0;
    overflow_buffers = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: a lone head byte, too short for any frame
    bytes_q = {HEAD_MARK};
    send_buffer();
    // smallest frame at index 0
    bytes_q = {HEAD_MARK, 8'h01, 8'h55, 8'h56, END_MARK};
    send_buffer();
    // checksum fails at the first head, search carries on to the second
    bytes_q = {HEAD_MARK, 8'h01, 8'h10, 8'h00, END_MARK,
               HEAD_MARK, 8'h01, 8'h10, 8'h11, END_MARK};
    send_buffer();
    // zero length is never a frame, in a buffer of exactly the minimum size
    bytes_q = {HEAD_MARK, 8'h00, 8'h00, END_MARK};
    send_buffer();
    // end byte would sit past the last stored byte
    bytes_q = {8'hFF, HEAD_MARK, 8'h02, 8'h01, 8'h02, 8'h05};
    send_buffer();

    // full buffer with a long frame ending on the top entry, then two more
    // items that get dropped, the flagged last one among them
    len = $urandom_range(128, 200);
    add_noise(DEPTH - 4 - len, 1'b0);
    add_frame(len, INTACT);
    add_noise(2, 1'b1);
    overflow_buffers++;
    send_buffer();

    // random part: mostly frames with random content, some spoilt, some noise
    while (bytes_sent < ITEM_TARGET) begin
      if ($urandom_range(99) < 15) begin
        add_noise($urandom_range(1, 12), 1'b1);
      end else begin
        add_noise($urandom_range(0, 5), 1'b1);
        if ($urandom_range(3) == 0)
          add_frame($urandom_range(1, 8), flaw_t'($urandom_range(BAD_SUM, CUT_SHORT)));
        if ($urandom_range(99) < 80) add_frame($urandom_range(1, 10), INTACT);
        else add_frame($urandom_range(1, 10), flaw_t'($urandom_range(BAD_SUM, CUT_SHORT)));
        add_noise($urandom_range(0, 3), 1'b1);
      end
      send_buffer();
    end
    start <= 1'b0;

    // drain, then give a stray result time to show up
    while (outstanding != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d bytes in %0d buffers (%0d with dropped bytes)",
             bytes_sent, buffers_sent, overflow_buffers);
    $display("compared %0d scan results, %0d mismatches", results_seen, fail_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("a6_frame_finder_core regression: pass");
    end else begin
      $display("a6_frame_finder_core regression: fail");
    end
    $finish;
  end

endmodule
